[rtl/core/chps_pkg.sv]
// ----------------------------------------------------------------------------
// Chaikin path subdivider package
// Shared types, register indexes and sequencing helpers for the subdivider
// and its distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package chps_pkg;

	// Top-level sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLAN,
		ST_POINT,
		ST_DGO,
		ST_DWAIT,
		ST_CGO,
		ST_CWAIT,
		ST_EMIT
	} top_state_t;

	// Distance unit states.
	typedef enum logic [1:0] {
		DS_IDLE,
		DS_MUL,
		DS_ROOT,
		DS_FIN
	} dist_state_t;

	// Kind of output point: every point is (3*h + l), scaled to the output format.
	typedef enum logic [2:0] {
		EK_COPY,
		EK_Q_PREV,
		EK_R_PREV,
		EK_Q_WRAP,
		EK_R_WRAP
	} emit_kind_t;

	// Partial products of a square split into a low and a high half.
	typedef enum logic [1:0] {
		PP_LL,
		PP_HL,
		PP_HH
	} pp_part_t;

	// Status of the distance unit as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} dist_stat_t;

	// Three coordinates, three partial products each.
	localparam logic [3:0] MUL_STEPS = 4'd9;

	// Word index of the closed_loop register.
	localparam logic REG_CLOSED_LOOP = 1'b0;

	// Coordinate handled at a given multiply step.
	function automatic logic [1:0] step_coord(input logic [3:0] step);
		logic [1:0] c;
		case (step) inside
			[4'd0:4'd2]: c = 2'd0;
			[4'd3:4'd5]: c = 2'd1;
			default:     c = 2'd2;
		endcase
		return c;
	endfunction

	// Partial product handled at a given multiply step.
	function automatic pp_part_t step_part(input logic [3:0] step);
		pp_part_t p;
		case (step) inside
			4'd0, 4'd3, 4'd6: p = PP_LL;
			4'd1, 4'd4, 4'd7: p = PP_HL;
			default:          p = PP_HH;
		endcase
		return p;
	endfunction

	// Kind of the k-th output point caused by one input point.
	function automatic emit_kind_t emit_kind(input logic started, input logic [1:0] k,
			input logic closed);
		emit_kind_t e;
		if (!started) begin
			e = EK_COPY;
		end else begin
			case (k)
				2'd0:    e = EK_Q_PREV;
				2'd1:    e = EK_R_PREV;
				2'd2:    e = closed ? EK_Q_WRAP : EK_COPY;
				default: e = EK_R_WRAP;
			endcase
		end
		return e;
	endfunction

	// Number of output points caused by one input point.
	function automatic logic [2:0] emit_count(input logic started, input logic fin,
			input logic closed);
		logic [2:0] n;
		if (!started) begin
			n = (fin || !closed) ? 3'd1 : 3'd0;
		end else if (fin) begin
			n = closed ? 3'd4 : 3'd3;
		end else begin
			n = 3'd2;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

[rtl/core/chps_dist.sv]
// ----------------------------------------------------------------------------
// Chaikin path subdivider distance unit
// Rounded Euclidean distance between two 3-D fixed-point points, built from
// one half-width multiplier and a digit-by-digit square root.
// ----------------------------------------------------------------------------
`default_nettype none

module chps_dist #(
	parameter int OUT_BITS = 18
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [OUT_BITS-1:0] pa [3],
	input  logic signed [OUT_BITS-1:0] pb [3],
	output chps_pkg::dist_stat_t       stat,
	output logic [OUT_BITS:0]          dist_val
);
	import chps_pkg::*;

	localparam int DIST_BITS = OUT_BITS + 1;
	localparam int SUM_BITS  = 2 * DIST_BITS;
	localparam int HALF      = (OUT_BITS + 1) / 2;
	localparam int RW        = DIST_BITS + 2;
	localparam int CNT_W     = $clog2(DIST_BITS);
	localparam logic [CNT_W-1:0] RCNT_LAST = CNT_W'(DIST_BITS - 1);

	dist_state_t state_q, state_d;

	logic signed [OUT_BITS:0]  dif_w [3];
	logic [OUT_BITS-1:0]       mag_w [3];
	logic [OUT_BITS-1:0]       d_q   [3];
	logic [3:0]                step_q;
	logic [OUT_BITS-1:0]       cur_w;
	logic [HALF-1:0]           lo_w, hi_w, op_a_w, op_b_w;
	logic [2*HALF-1:0]         prod_w, prod_q;
	pp_part_t                  prod_part_q;
	logic [SUM_BITS-1:0]       pp_shift_w, acc_q;
	logic [CNT_W-1:0]          rcnt_q;
	logic [DIST_BITS-1:0]      root_q;
	logic [RW-1:0]             rem_q, rem_shift_w, trial_w;
	logic                      ge_w;
	logic [DIST_BITS-1:0]      dist_q;
	logic                      done_q;
	logic                      mul_issue_w, mul_acc_w;

	// Absolute coordinate differences, taken when a distance starts.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif_w[i] = (OUT_BITS + 1)'(pa[i]) - (OUT_BITS + 1)'(pb[i]);
			mag_w[i] = dif_w[i][OUT_BITS] ? OUT_BITS'(-dif_w[i]) : OUT_BITS'(dif_w[i]);
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		cur_w = d_q[step_coord(step_q)];
		lo_w  = cur_w[HALF-1:0];
		hi_w  = HALF'(cur_w[OUT_BITS-1:HALF]);
		case (step_part(step_q))
			PP_LL:   begin op_a_w = lo_w; op_b_w = lo_w; end
			PP_HL:   begin op_a_w = hi_w; op_b_w = lo_w; end
			default: begin op_a_w = hi_w; op_b_w = hi_w; end
		endcase
	end

	assign prod_w = op_a_w * op_b_w;

	// Weight of the registered partial product; the cross term counts twice.
	always_comb begin
		case (prod_part_q)
			PP_LL:   pp_shift_w = SUM_BITS'(prod_q);
			PP_HL:   pp_shift_w = SUM_BITS'(prod_q) << (HALF + 1);
			default: pp_shift_w = SUM_BITS'(prod_q) << (2 * HALF);
		endcase
	end

	// One square root digit: bring down two bits of the sum and try a one.
	assign rem_shift_w = {rem_q[RW-3:0], acc_q[SUM_BITS-1 -: 2]};
	assign trial_w     = {root_q, 2'b01};
	assign ge_w        = (rem_shift_w >= trial_w);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			DS_IDLE: if (start) state_d = DS_MUL;
			DS_MUL:  if (step_q == MUL_STEPS) state_d = DS_ROOT;
			DS_ROOT: if (rcnt_q == RCNT_LAST) state_d = DS_FIN;
			DS_FIN:  state_d = DS_IDLE;
			default: state_d = DS_IDLE;
		endcase
	end

	// Multiplier strobes.
	always_comb begin
		mul_issue_w = (state_q == DS_MUL) && (step_q != MUL_STEPS);
		mul_acc_w   = (state_q == DS_MUL) && (step_q != 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DS_FIN);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == DS_IDLE && start) begin
			for (int i = 0; i < 3; i++) begin
				d_q[i] <= mag_w[i];
			end
			step_q <= '0;
			acc_q  <= '0;
			rcnt_q <= '0;
			root_q <= '0;
			rem_q  <= '0;
		end
		if (mul_issue_w) begin
			prod_q      <= prod_w;
			prod_part_q <= step_part(step_q);
		end
		if (state_q == DS_MUL) begin
			step_q <= step_q + 4'd1;
		end
		if (mul_acc_w) begin
			acc_q <= acc_q + pp_shift_w;
		end
		if (state_q == DS_ROOT) begin
			rem_q  <= ge_w ? rem_shift_w - trial_w : rem_shift_w;
			root_q <= {root_q[DIST_BITS-2:0], ge_w};
			acc_q  <= acc_q << 2;
			rcnt_q <= rcnt_q + CNT_W'(1);
		end
		// Round to nearest: the remainder exceeds the root past the half point.
		if (state_q == DS_FIN) begin
			dist_q <= root_q + DIST_BITS'(rem_q > RW'(root_q));
		end
	end

	assign stat.busy = (state_q != DS_IDLE);
	assign stat.done = done_q;
	assign dist_val  = dist_q;

endmodule

`default_nettype wire

[rtl/core/chaikin_path_subdivider.sv]
// ----------------------------------------------------------------------------
// Chaikin path subdivider
// One pass of Chaikin corner cutting over a streamed 3-D path, with the
// distance between consecutive output points.
// ----------------------------------------------------------------------------
// Points enter as words on the slave stream, tlast marking the last point of a
// path, and leave as up to four words per point on the master stream. The block
// handles one point at a time and is not ready until all of its words are out.
// Each output word but the first of a path waits for the shared distance unit:
// nine half-width multiply steps for the squared length, then one square root
// digit per cycle. The last word of a closed path needs a second distance, to
// the first output point. A point that gives no word (the first point of a
// closed path) goes from the plan state straight back to idle. closed_loop is
// sampled when the first point of a path is accepted.
`default_nettype none

module chaikin_path_subdivider #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Point input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pos_x, pos_y, pos_z from the lowest bit up
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	// Point output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_x, out_y, out_z, dist_to_prev, closing_dist from the lowest bit up
	output logic [((5*(COORD_BITS+FRAC_BITS)+2+7)/8)*8-1:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import chps_pkg::*;

	localparam int OUT_BITS  = COORD_BITS + FRAC_BITS;
	localparam int DIST_BITS = OUT_BITS + 1;
	localparam int OUT_TD    = ((5 * OUT_BITS + 2 + 7) / 8) * 8;

	top_state_t state_q, state_d;

	logic                         closed_q;
	logic                         started_q, path_closed_q, have_out_q;
	logic signed [COORD_BITS-1:0] in_q       [3];
	logic                         fin_q;
	logic signed [COORD_BITS-1:0] prev_in_q  [3];
	logic signed [COORD_BITS-1:0] first_in_q [3];
	logic signed [OUT_BITS-1:0]   first_out_q[3];
	logic signed [OUT_BITS-1:0]   prev_out_q [3];
	logic signed [OUT_BITS-1:0]   pt_q       [3];
	logic [2:0]                   k_q;
	logic [DIST_BITS-1:0]         dprev_q, dclose_q;

	logic signed [OUT_BITS-1:0]   out_x_q, out_y_q, out_z_q;
	logic [DIST_BITS-1:0]         out_dprev_q, out_dclose_q;
	logic                         out_last_q, out_valid_q;

	emit_kind_t                   kind_w;
	logic [2:0]                   n_w;
	logic                         is_close_w;
	logic signed [COORD_BITS-1:0] h_w [3];
	logic signed [COORD_BITS-1:0] l_w [3];
	logic signed [OUT_BITS-1:0]   hx_w, lx_w;
	logic signed [OUT_BITS-1:0]   blend_w [3];
	logic signed [OUT_BITS-1:0]   dist_pb_w [3];

	logic                         accept_w, cfg_wr_w;
	logic                         plan_done_w, pt_load_w, dist_start_w, dist_close_sel_w;
	logic                         dprev_zero_w, dprev_cap_w, dclose_cap_w, emit_w;

	dist_stat_t                   dstat;
	logic [DIST_BITS-1:0]         dist_w;

	// Configuration register.
	assign pready   = 1'b1;
	assign cfg_wr_w = psel && penable && pwrite && pready && (paddr[2] == REG_CLOSED_LOOP);
	assign prdata   = (paddr[2] == REG_CLOSED_LOOP) ? {31'd0, closed_q} : 32'd0;

	// Plan for the current input point.
	always_comb begin
		kind_w     = emit_kind(started_q, k_q[1:0], path_closed_q);
		n_w        = emit_count(started_q, fin_q, path_closed_q);
		is_close_w = (kind_w == EK_R_WRAP);
	end

	// Corner cut: every point is 3*h + l, which lands exactly on the output grid.
	always_comb begin
		hx_w = '0;
		lx_w = '0;
		for (int i = 0; i < 3; i++) begin
			case (kind_w)
				EK_Q_PREV: begin h_w[i] = prev_in_q[i];  l_w[i] = in_q[i];       end
				EK_R_PREV: begin h_w[i] = in_q[i];       l_w[i] = prev_in_q[i];  end
				EK_Q_WRAP: begin h_w[i] = in_q[i];       l_w[i] = first_in_q[i]; end
				EK_R_WRAP: begin h_w[i] = first_in_q[i]; l_w[i] = in_q[i];       end
				default:   begin h_w[i] = in_q[i];       l_w[i] = in_q[i];       end
			endcase
			hx_w       = OUT_BITS'(h_w[i]);
			lx_w       = OUT_BITS'(l_w[i]);
			blend_w[i] = ((hx_w <<< 1) + hx_w + lx_w) <<< (FRAC_BITS - 2);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_axis_tvalid) state_d = ST_PLAN;
			ST_PLAN:  state_d = (k_q == n_w) ? ST_IDLE : ST_POINT;
			ST_POINT: begin
				if (have_out_q) begin
					state_d = ST_DGO;
				end else begin
					state_d = is_close_w ? ST_CGO : ST_EMIT;
				end
			end
			ST_DGO:   if (!dstat.busy) state_d = ST_DWAIT;
			ST_DWAIT: if (dstat.done) state_d = is_close_w ? ST_CGO : ST_EMIT;
			ST_CGO:   if (!dstat.busy) state_d = ST_CWAIT;
			ST_CWAIT: if (dstat.done) state_d = ST_EMIT;
			ST_EMIT:  if (!out_valid_q || m_axis_tready) state_d = ST_PLAN;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_axis_tready    = (state_q == ST_IDLE);
		plan_done_w      = (state_q == ST_PLAN) && (k_q == n_w);
		pt_load_w        = (state_q == ST_PLAN) && (k_q != n_w);
		dist_start_w     = (state_q == ST_DGO || state_q == ST_CGO) && !dstat.busy;
		dist_close_sel_w = (state_q == ST_CGO);
		dprev_zero_w     = (state_q == ST_POINT) && !have_out_q;
		dprev_cap_w      = (state_q == ST_DWAIT) && dstat.done;
		dclose_cap_w     = (state_q == ST_CWAIT) && dstat.done;
		emit_w           = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
	end

	assign accept_w = s_axis_tvalid && s_axis_tready;

	// The second operand is the previous output, or the first one when closing.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dist_pb_w[i] = dist_close_sel_w ? first_out_q[i] : prev_out_q[i];
		end
	end

	chps_dist #(
		.OUT_BITS (OUT_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dist_start_w),
		.pa       (pt_q),
		.pb       (dist_pb_w),
		.stat     (dstat),
		.dist_val (dist_w)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			closed_q      <= 1'b0;
			started_q     <= 1'b0;
			path_closed_q <= 1'b0;
			have_out_q    <= 1'b0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_w) begin
				closed_q <= pwdata[0];
			end
			if (accept_w) begin
				k_q <= '0;
				if (!started_q) begin
					path_closed_q <= closed_q;
				end
			end
			// End of the point: a final point clears the whole path.
			if (plan_done_w) begin
				if (fin_q) begin
					started_q     <= 1'b0;
					path_closed_q <= 1'b0;
					have_out_q    <= 1'b0;
				end else begin
					started_q <= 1'b1;
				end
			end
			if (emit_w) begin
				have_out_q <= 1'b1;
				k_q        <= k_q + 3'd1;
			end
			if (emit_w) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Point and result registers.
	always_ff @(posedge clk) begin
		if (accept_w) begin
			in_q[0] <= s_axis_tdata[COORD_BITS-1:0];
			in_q[1] <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
			in_q[2] <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
			fin_q   <= s_axis_tlast;
		end
		if (plan_done_w && !fin_q) begin
			prev_in_q <= in_q;
			if (!started_q) begin
				first_in_q <= in_q;
			end
		end
		if (pt_load_w) begin
			pt_q <= blend_w;
		end
		if (dprev_zero_w) begin
			dprev_q <= '0;
		end
		if (dprev_cap_w) begin
			dprev_q <= dist_w;
		end
		if (dclose_cap_w) begin
			dclose_q <= dist_w;
		end
		if (emit_w) begin
			prev_out_q <= pt_q;
			if (!have_out_q) begin
				first_out_q <= pt_q;
			end
			out_x_q      <= pt_q[0];
			out_y_q      <= pt_q[1];
			out_z_q      <= pt_q[2];
			out_dprev_q  <= dprev_q;
			out_dclose_q <= is_close_w ? dclose_q : '0;
			out_last_q   <= fin_q && ((k_q + 3'd1) == n_w);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TD'({out_dclose_q, out_dprev_q, out_z_q, out_y_q, out_x_q});
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

[rtl/core/chps_checker.sv]
// ----------------------------------------------------------------------------
// Chaikin path subdivider checker
// Port-level checks on the subdivider's streams, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chps_checker #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 2
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [((5*(COORD_BITS+FRAC_BITS)+2+7)/8)*8-1:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	localparam int OUT_BITS  = COORD_BITS + FRAC_BITS;
	localparam int DIST_BITS = OUT_BITS + 1;
	localparam int DPREV_LO  = 3 * OUT_BITS;
	localparam int DCLOSE_LO = 3 * OUT_BITS + DIST_BITS;

	logic first_pend_q;

	// Set while the next output word opens a new path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pend_q <= 1'b1;
		end else if (m_axis_tvalid && m_axis_tready) begin
			first_pend_q <= m_axis_tlast;
		end
	end

	// The block works on one point at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a point is in progress");

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// The first word of a path has no previous point.
	a_first_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && first_pend_q |->
			m_axis_tdata[DPREV_LO+DIST_BITS-1:DPREV_LO] == '0)
		else $error("first word of a path carries a distance");

	// Only the last word of a path may carry a closing distance.
	a_close_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |->
			m_axis_tdata[DCLOSE_LO+DIST_BITS-1:DCLOSE_LO] == '0)
		else $error("closing distance on a word that does not end the path");

endmodule

bind chaikin_path_subdivider chps_checker #(
	.COORD_BITS (COORD_BITS),
	.FRAC_BITS  (FRAC_BITS)
) u_chps_checker (.*);

`default_nettype wire

[sim/chaikin_path_subdivider_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chaikin path subdivider checker
// Watches the configuration port and both streams, predicts the cut points of
// every accepted point word and compares each output word with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------

module chaikin_path_subdivider_checker #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// pos_x, pos_y, pos_z from the lowest bit up
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_x, out_y, out_z, dist_to_prev, closing_dist from the lowest bit up
	input  logic [((5*(COORD_BITS+FRAC_BITS)+2+7)/8)*8-1:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending
);
	import chps_pkg::*;

	localparam int OB = COORD_BITS + FRAC_BITS;
	localparam int DB = OB + 1;
	localparam logic [2:0] CLOSED_LOOP_ADDR = 3'(4 * REG_CLOSED_LOOP);
	localparam longint SCALE = longint'(1) << (FRAC_BITS - 2);

	typedef struct packed {
		logic [OB-1:0] x;
		logic [OB-1:0] y;
		logic [OB-1:0] z;
		logic [DB-1:0] dprev;
		logic [DB-1:0] closing;
		logic          last;
	} vertex_t;

	vertex_t vertex_q[$];
	vertex_t got;
	vertex_t want;

	// Own copy of the closed_loop register and of the path state.
	logic   loop_cfg;
	logic   in_path;
	logic   path_closed;
	logic   any_vertex;
	longint prior_pt[3];
	longint head_pt[3];
	longint head_vert[3];
	longint tail_vert[3];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Euclidean distance rounded to nearest, halves up.
	function automatic longint unsigned span(input longint a[3], input longint b[3]);
		longint unsigned sq;
		longint unsigned root;
		longint unsigned trial;
		longint unsigned d;
		int i;
		int k;
		sq = 0;
		for (i = 0; i < 3; i++) begin
			d = (a[i] >= b[i]) ? longint'(a[i] - b[i]) : longint'(b[i] - a[i]);
			sq += d * d;
		end
		root = 0;
		for (k = 24; k >= 0; k--) begin
			trial = root | (64'd1 << k);
			if (trial * trial <= sq)
				root = trial;
		end
		if (sq > root * root + root)
			root++;
		return root & ((64'd1 << DB) - 1);
	endfunction

	task automatic clear_path();
		int i;
		in_path = 1'b0;
		path_closed = 1'b0;
		any_vertex = 1'b0;
		for (i = 0; i < 3; i++) begin
			prior_pt[i] = 0;
			head_pt[i] = 0;
			head_vert[i] = 0;
			tail_vert[i] = 0;
		end
	endtask

	// Queue the point (wa*a + wb*b)/4 in the output format.
	task automatic add_vertex(input longint a[3], input longint b[3], input longint wa,
			input longint wb);
		longint p[3];
		vertex_t v;
		int i;
		for (i = 0; i < 3; i++)
			p[i] = (wa * a[i] + wb * b[i]) * SCALE;
		v.dprev = any_vertex ? DB'(span(p, tail_vert)) : '0;
		if (!any_vertex)
			head_vert = p;
		tail_vert = p;
		any_vertex = 1'b1;
		v.x = OB'(p[0]);
		v.y = OB'(p[1]);
		v.z = OB'(p[2]);
		v.closing = '0;
		v.last = 1'b0;
		vertex_q.insert(vertex_q.size(), v);
	endtask

	// Mark the newest prediction as the end of its path.
	task automatic close_tail(input logic with_closing);
		vertex_t v;
		v = vertex_q[vertex_q.size() - 1];
		v.last = 1'b1;
		if (with_closing)
			v.closing = DB'(span(tail_vert, head_vert));
		vertex_q[vertex_q.size() - 1] = v;
	endtask

	task automatic predict_point(input longint p[3], input logic fin);
		if (!in_path) begin
			path_closed = loop_cfg;
			if (fin || !path_closed)
				add_vertex(p, p, 4, 0);
			if (fin) begin
				close_tail(1'b0);
				clear_path();
			end else begin
				in_path = 1'b1;
				prior_pt = p;
				head_pt = p;
			end
		end else begin
			add_vertex(prior_pt, p, 3, 1);
			add_vertex(prior_pt, p, 1, 3);
			prior_pt = p;
			if (fin) begin
				if (path_closed) begin
					add_vertex(p, head_pt, 3, 1);
					add_vertex(p, head_pt, 1, 3);
					close_tail(1'b1);
				end else begin
					add_vertex(p, p, 4, 0);
					close_tail(1'b0);
				end
				clear_path();
			end
		end
	endtask

	task automatic check_word();
		got.x = m_axis_tdata[OB-1:0];
		got.y = m_axis_tdata[2*OB-1:OB];
		got.z = m_axis_tdata[3*OB-1:2*OB];
		got.dprev = m_axis_tdata[3*OB+DB-1:3*OB];
		got.closing = m_axis_tdata[3*OB+2*DB-1:3*OB+DB];
		got.last = m_axis_tlast;
		if (vertex_q.size() == 0) begin
			if (fail_count < 10)
				$display("%0t: output word with no point waiting: x=%0d y=%0d z=%0d",
					$time, $signed(got.x), $signed(got.y), $signed(got.z));
			fail_count++;
		end else begin
			want = vertex_q.pop_front();
			if (got.x != want.x || got.y != want.y || got.z != want.z ||
					got.dprev != want.dprev || got.closing != want.closing ||
					got.last != want.last) begin
				if (fail_count < 10) begin
					$display("%0t: expected x=%0d y=%0d z=%0d dist=%0d closing=%0d last=%0b",
						$time, $signed(want.x), $signed(want.y), $signed(want.z),
						want.dprev, want.closing, want.last);
					$display("%0t:      got x=%0d y=%0d z=%0d dist=%0d closing=%0d last=%0b",
						$time, $signed(got.x), $signed(got.y), $signed(got.z),
						got.dprev, got.closing, got.last);
				end
				fail_count++;
			end
		end
	endtask

	// Outputs are checked before the point accepted at the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		longint pt[3];
		if (!arst_n) begin
			loop_cfg = 1'b0;
			clear_path();
			vertex_q.delete();
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_word();
			if (psel && penable && pwrite && pready && paddr == CLOSED_LOOP_ADDR)
				loop_cfg = pwdata[0];
			if (s_axis_tvalid && s_axis_tready) begin
				pt[0] = longint'($signed(s_axis_tdata[COORD_BITS-1:0]));
				pt[1] = longint'($signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
				pt[2] = longint'($signed(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]));
				predict_point(pt, s_axis_tlast);
			end
			pending = vertex_q.size();
		end
	end

endmodule

[sim/chaikin_path_subdivider_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chaikin path subdivider testbench
// Drives open and closed paths into the subdivider, first a directed set of
// extreme and corner paths, then random paths under several idling patterns,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module chaikin_path_subdivider_test;
	import chps_pkg::*;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 2;
	localparam int IN_W  = ((3*COORD_BITS+7)/8)*8;
	localparam int OUT_W = ((5*(COORD_BITS+FRAC_BITS)+2+7)/8)*8;
	localparam logic [2:0] CLOSED_LOOP_ADDR = 3'(4 * REG_CLOSED_LOOP);
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_POINTS = 60;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             s_axis_tlast = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tlast;

	int fail_count;
	int pending;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int quiet_cycles = 0;
	int points_sent;

	chaikin_path_subdivider #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	chaikin_path_subdivider_checker #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// The receiver stalls at random at the rate of the current phase.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Watchdog: ends the run when nothing has been accepted for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable && pready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("chaikin_path_subdivider_test NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [COORD_BITS-1:0] pick_coord();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return COORD_BITS'($urandom);
		if (roll < 80) begin
			case ($urandom_range(0, 3))
				0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
				1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
				2:       return '0;
				default: return '1;
			endcase
		end
		return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
	endfunction

	// Present one point word and hold it until the block takes it.
	task automatic send_point(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
			input logic [COORD_BITS-1:0] pz, input logic fin);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_W'({pz, py, px});
		s_axis_tlast <= fin;
		do
			@(posedge clk);
		while (!s_axis_tready);
		points_sent++;
	endtask

	// Stop sending and wait until every predicted word has come out.
	task automatic drain(input int settle);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_closed_loop(input logic value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CLOSED_LOOP_ADDR;
		pwdata <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One random path; now and then the sender waits for the block to empty and
	// rewrites the register, sometimes in the middle of the path.
	task automatic send_random_path(input int len);
		int i;
		int rewrite_at;
		rewrite_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
		for (i = 0; i < len; i++) begin
			if (i == rewrite_at) begin
				drain(10);
				write_closed_loop(1'($urandom));
			end
			send_point(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
		end
	endtask

	initial begin
		int phase;
		int len;
		points_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Open paths: a single point, then extremes in every coordinate.
		send_point(16'h8000, 16'h7fff, 16'hffff, 1'b1);
		send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
		send_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
		send_point(16'h0000, 16'h0000, 16'h0000, 1'b1);
		send_point(16'h7fff, 16'h8000, 16'h0001, 1'b0);
		send_point(16'h8000, 16'h7fff, 16'hfffe, 1'b1);
		drain(10);
		write_closed_loop(1'b1);

		// Closed paths: a single point, a two-point loop across the whole range,
		// and a loop whose register is cleared halfway through, then an open path.
		send_point(16'h7fff, 16'h7fff, 16'h8000, 1'b1);
		send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
		send_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
		send_point(16'h0003, 16'hfff9, 16'h0100, 1'b0);
		send_point(16'h8000, 16'h7fff, 16'h8000, 1'b0);
		drain(10);
		write_closed_loop(1'b0);
		send_point(16'h7fff, 16'h8000, 16'h7fff, 1'b1);
		send_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_point(16'h0001, 16'hffff, 16'h0000, 1'b1);

		// Random paths under four idling patterns.
		for (phase = 0; phase < 4; phase++) begin
			drain(10);
			write_closed_loop(phase == 1 ? 1'b1 : phase == 0 ? 1'b0 : 1'($urandom));
			case (phase)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 88;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 88;
				end
				default: begin
					src_idle_pct = 7;
					sink_stall_pct = 7;
				end
			endcase
			points_sent = 0;
			while (points_sent < PHASE_POINTS) begin
				len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
				send_random_path(len);
			end
		end

		drain(200);
		if (fail_count == 0) begin
			$display("chaikin_path_subdivider_test OK");
		end else begin
			$display("chaikin_path_subdivider_test NOT OK");
		end
		$finish;
	end

endmodule
